@@ design/sha_pkg.sv @@
// ============================================================================
// SHA-256 stream hasher package
// Item types, round constants, initial hash values and round functions.
// ============================================================================
package sha_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ZERO,
		ST_LEN,
		ST_COMP,
		ST_EMIT
	} back_state_t;

	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] v, input int n);
		ror = (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] ep0(input logic [31:0] x);
		ep0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] ep1(input logic [31:0] x);
		ep1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

endpackage

@@ design/sha_front.sv @@
// ============================================================================
// SHA-256 front end
// Accepts input items into a short queue toward the back end.
// ============================================================================
module sha_front import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output logic     q_valid,
	input  logic     q_take,
	output in_item_t q_data
);

	in_item_t   mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_stall = (cnt_q == 3'd4);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 3'd0);
	assign pop      = q_valid && q_take;
	assign q_data   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 2'd1;
			end
			if (pop) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

endmodule

@@ design/sha_back.sv @@
// ============================================================================
// SHA-256 back end
// Block buffer, padding sequencer, one-round-per-cycle compression, output.
// ============================================================================
module sha_back import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_take,
	input  in_item_t  q_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	back_state_t state_q;
	back_state_t state_d;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [5:0]  pos_q;
	logic [63:0] bits_q;
	logic [5:0]  rnd_q;
	logic        final_q;
	logic        pad_q;
	logic [2:0]  emit_q;
	logic [7:0]  wr_byte;
	logic        wr_en;
	logic        start_comp;
	logic [31:0] wnext;
	logic [31:0] wt;
	logic [31:0] t1;
	logic [31:0] t2;
	logic        pad_two;
	logic        out_fire;

	assign out_fire = out_valid && !out_stall;
	assign pad_two  = pos_q > 6'd55;
	assign wnext    = w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);
	assign wt       = w_q[0];
	assign t1 = v_q[7] + ep1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ ROUND_K[rnd_q] + wt;
	assign t2 = ep0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_data.kind == KIND_END) begin
						state_d = ST_PAD;
					end else if (pos_q == 6'd63) begin
						state_d = ST_COMP;
					end
				end
			end
			ST_PAD: begin
				if (pos_q == 6'd63) begin
					state_d = ST_COMP;
				end else if (pos_q == 6'd55) begin
					state_d = ST_LEN;
				end else begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (final_q && pos_q == 6'd55) begin
					state_d = ST_LEN;
				end else if (!final_q && pos_q == 6'd63) begin
					state_d = ST_COMP;
				end
			end
			ST_LEN: begin
				if (pos_q == 6'd63) begin
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				if (rnd_q == 6'd63) begin
					if (final_q) begin
						state_d = ST_EMIT;
					end else if (pad_q) begin
						state_d = ST_ZERO;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (out_fire && emit_q == 3'd7) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_take     = (state_q == ST_IDLE);
		wr_en      = 1'b0;
		wr_byte    = 8'h00;
		start_comp = 1'b0;
		out_valid  = (state_q == ST_EMIT);
		out_data.digest_word = h_q[emit_q];
		out_data.word_index  = emit_q;
		out_data.last_word   = (emit_q == 3'd7);
		case (state_q)
			ST_IDLE: begin
				if (q_valid && q_data.kind == KIND_BYTE) begin
					wr_en      = 1'b1;
					wr_byte    = q_data.data_byte;
					start_comp = (pos_q == 6'd63);
				end
			end
			ST_PAD: begin
				wr_en      = 1'b1;
				wr_byte    = 8'h80;
				start_comp = (pos_q == 6'd63);
			end
			ST_ZERO: begin
				wr_en      = 1'b1;
				start_comp = (pos_q == 6'd63);
			end
			ST_LEN: begin
				wr_en      = 1'b1;
				wr_byte    = bits_q[8*(7 - (pos_q[2:0])) +: 8];
				start_comp = (pos_q == 6'd63);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			bits_q  <= '0;
			rnd_q   <= '0;
			final_q <= 1'b0;
			pad_q   <= 1'b0;
			emit_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (state_q == ST_IDLE && q_valid) begin
				if (q_data.kind == KIND_BYTE) begin
					bits_q <= bits_q + 64'd8;
				end else begin
					final_q <= !pad_two;
					pad_q   <= 1'b1;
				end
			end
			if (state_q == ST_ZERO && state_d == ST_LEN) begin
				final_q <= 1'b1;
			end
			if (start_comp) begin
				rnd_q <= '0;
			end else if (state_q == ST_COMP) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + (i == 0 ? t1 + t2 : (i == 4 ? v_q[3] + t1 :
							v_q[i - 1]));
					end
					if (final_q) begin
						emit_q <= '0;
					end
				end
			end
			if (state_q == ST_COMP && rnd_q == 6'd63 && !final_q && pad_q) begin
				final_q <= 1'b1;
			end
			if (out_fire) begin
				emit_q <= emit_q + 3'd1;
				if (emit_q == 3'd7) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= H_INIT[i];
					end
					bits_q  <= '0;
					pos_q   <= '0;
					final_q <= 1'b0;
					pad_q   <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (pos_q[1:0] == 2'd0) begin
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i + 1];
				end
				w_q[15] <= {wr_byte, 24'h000000};
			end else begin
				w_q[15][{~pos_q[1:0], 3'b000} +: 8] <= wr_byte;
			end
		end else if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wnext;
		end
		if (start_comp) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == ST_COMP) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

endmodule

@@ design/sha256_stream_hasher.sv @@
// ============================================================================
// SHA-256 stream hasher
// Byte-stream SHA-256 with padding and eight-word digest output.
// ============================================================================
//  channel | dir | payload    | handshake
//  in      | in  | in_item_t  | in_valid / in_stall
//  out     | out | out_item_t | out_valid / out_stall
//
// Byte items are taken from the queue while the back end is idle; the 64th
// byte of a block starts compression, one round per cycle in the back end.
// End of message: the end item is taken, the 0x80 byte, zero bytes and the
// 64-bit length are written over one or two compressions, then eight output
// words follow. A four-entry queue takes items while the back end is busy.
// Reset restores the initial hash values; the block buffer is not cleared.
module sha256_stream_hasher import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic     q_valid;
	logic     q_take;
	in_item_t q_data;

	sha_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.q_valid, .q_take, .q_data
	);

	sha_back u_back (
		.clk, .arst_n, .q_valid, .q_take, .q_data,
		.out_valid, .out_stall, .out_data
	);

endmodule

@@ test/sha256_stream_hasher_tb.sv @@
// ============================================================================
// SHA-256 stream hasher testbench
// Streams byte/end-of-message words into the hasher, predicts each digest
// with a behavioral SHA-256 and checks every output word in order, under
// random idling on both channels.
// ============================================================================
module sha256_stream_hasher_tb import sha_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	class digest_scoreboard;
		logic [31:0] hash_state [8];
		logic [7:0]  block_bytes [64];
		logic [5:0]  fill_count;
		logic [63:0] bit_length;
		out_item_t   pending_words [$];
		int          error_count;
		int          digest_count;

		function new();
			error_count = 0;
			digest_count = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++)
				hash_state[i] = H_INIT[i];
			fill_count = '0;
			bit_length = '0;
		endfunction

		function logic [31:0] rotr(logic [31:0] v, int n);
			return (v >> n) | (v << (32 - n));
		endfunction

		function void compress();
			logic [31:0] sched [64];
			logic [31:0] r [8];
			logic [31:0] t1, t2;
			for (int t = 0; t < 16; t++)
				sched[t] = {block_bytes[4*t], block_bytes[4*t+1],
					block_bytes[4*t+2], block_bytes[4*t+3]};
			for (int t = 16; t < 64; t++)
				sched[t] = sched[t-16] + sched[t-7]
					+ (rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3))
					+ (rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10));
			r = hash_state;
			for (int t = 0; t < 64; t++) begin
				t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
					+ ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_K[t] + sched[t];
				t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
					+ ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
				r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
				r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				hash_state[i] += r[i];
		endfunction

		function void note_word(in_item_t w);
			int pos;
			out_item_t o;
			if (w.kind == KIND_BYTE) begin
				block_bytes[fill_count] = w.data_byte;
				fill_count++;
				bit_length += 64'd8;
				if (fill_count == 0)
					compress();
				return;
			end
			pos = fill_count;
			block_bytes[pos++] = 8'h80;
			if (pos > 56) begin
				while (pos < 64)
					block_bytes[pos++] = 0;
				compress();
				pos = 0;
			end
			while (pos < 56)
				block_bytes[pos++] = 0;
			for (int j = 0; j < 8; j++)
				block_bytes[63-j] = bit_length[8*j +: 8];
			compress();
			for (int j = 0; j < 8; j++) begin
				o.digest_word = hash_state[j];
				o.word_index = 3'(j);
				o.last_word = (j == 7);
				pending_words.push_back(o);
			end
			digest_count++;
			restart();
		endfunction

		function void check_word(out_item_t got);
			out_item_t exp;
			if (pending_words.size() == 0) begin
				$error("unexpected output word %h", got);
				error_count++;
				return;
			end
			exp = pending_words.pop_front();
			if (got.digest_word !== exp.digest_word) begin
				$error("digest_word: expected %h, got %h", exp.digest_word, got.digest_word);
				error_count++;
			end
			if (got.word_index !== exp.word_index) begin
				$error("word_index: expected %0d, got %0d", exp.word_index, got.word_index);
				error_count++;
			end
			if (got.last_word !== exp.last_word) begin
				$error("last_word: expected %0d, got %0d", exp.last_word, got.last_word);
				error_count++;
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 20000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	digest_scoreboard sb;
	bit quiet_phase;
	int idle_cycles;
	int words_sent;

	sha256_stream_hasher i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	task automatic send_word(input logic kind, input logic [7:0] b);
		in_item_t w;
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		w.kind = kind;
		w.data_byte = b;
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		sb.note_word(w);
		words_sent++;
	endtask

	task automatic send_message(input int len, input int pattern);
		for (int i = 0; i < len; i++)
			case (pattern)
			0: send_word(KIND_BYTE, 8'h00);
			1: send_word(KIND_BYTE, 8'hff);
			default: send_word(KIND_BYTE, 8'($urandom_range(0, 255)));
			endcase
		send_word(KIND_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.pending_words.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(out_data);
		if (!arst_n)
			out_stall <= 0;
		else if (quiet_phase)
			out_stall <= 0;
		else if (idle_cycles > 0) begin
			idle_cycles <= idle_cycles - 1;
			out_stall <= 1;
		end else if ($urandom_range(0, 7) == 0) begin
			idle_cycles <= $urandom_range(0, 14);
			out_stall <= 1;
		end else
			out_stall <= 0;
	end

	int stuck_cycles;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles", stuck_cycles);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int len;
		sb = new();
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		quiet_phase = 0;
		idle_cycles = 0;
		words_sent = 0;
		stuck_cycles = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: empty, boundary lengths around padding split, extreme bytes
		send_message(0, 2);
		send_message(1, 0);
		send_message(3, 1);
		send_message(8, 2);
		send_message(2, 1);
		wait_drained();
		send_word(KIND_END, 8'hff);
		send_word(KIND_END, 8'h00);
		wait_drained();
		send_message(55, 2);
		send_message(56, 1);
		send_message(63, 2);
		send_message(64, 0);
		// random messages, mostly short
		while (words_sent < 280) begin
			if (words_sent > 250)
				quiet_phase = 1;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 70) : $urandom_range(0, 12);
			send_message(len, $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 2);
		end
		wait_drained();
		repeat (200) @(posedge clk);
		$display("Hashed %0d messages from %0d input words, lengths 0 to 70 bytes.",
			sb.digest_count, words_sent);
		if (sb.error_count == 0 && sb.pending_words.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

@@ sha256_stream_hasher.f @@
design/sha_pkg.sv
design/sha_front.sv
design/sha_back.sv
design/sha256_stream_hasher.sv
test/sha256_stream_hasher_tb.sv
